// ===== sv/psa_pkg.sv =====
// Package for the priority scheduler with aging: sizes, codes and item types.
// No dependencies; imported by priority_scheduler_with_aging.
package psa_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [3:0] PRIO_MIN    = 4'd1;
    localparam logic [3:0] PRIO_MAX    = 4'd10;
    localparam logic [3:0] BURST_RESET = 4'd2;

    typedef enum logic [2:0] {
        STAT_ENQ     = 3'd0,
        STAT_DEQ     = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_BADPRIO = 3'd3,
        STAT_FULL    = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] in_value;
        logic [3:0]  in_priority;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_value;
        logic [3:0]  out_priority;
    } t_rsp;

    typedef struct packed {
        logic [3:0]  prio;
        logic [15:0] value;
    } t_entry;

endpackage

// ===== sv/priority_scheduler_with_aging.sv =====
// Priority scheduler with aging: entry store in one synchronous RAM, scan and compaction.
// Depends on psa_pkg.
//
// Usage:
//   Command channel: an item (i_req) is taken at a clock edge where start is high and
//   busy is low. Each item yields exactly one result on o_result, shown for one cycle
//   with o_done high; the receiver cannot stall it.
//   Config channel: i_cfg_burst_limit is written when i_cfg_valid is high (o_cfg_ready
//   is always high). Write it only while busy is low and no result is pending.
//   Short items: an enqueue, a rejected enqueue or an empty dequeue gives its result in
//   the cycle after acceptance and busy stays low, so one such item can be taken per cycle.
//   A dequeue scans stored entries through the single RAM read port, one entry per
//   cycle (all of them, or only the oldest when the burst limit is reached), then
//   compacts the entries behind the removed one, one read and one write per cycle.
//   Busy stays high through the scan and the compaction; the result shows as busy drops.
//   Reset: the store is empty, the run count is zero, burst limit is 2. The RAM
//   contents are not cleared; only entries below the fill count are ever read.
module priority_scheduler_with_aging
    import psa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_req       i_req,
    output logic       busy,
    output logic       o_done,
    output t_rsp       o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_burst_limit
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [3:0]    r_run;
    logic [3:0]    r_burst;
    logic          r_done;
    logic          r_pend;
    t_rsp          r_result;

    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_pend_addr;
    logic [CW-1:0] r_limit;
    logic [CW-1:0] r_bpos;
    logic [CW-1:0] pend_prev;
    t_entry        r_best;
    t_entry        r_rd_data;
    t_entry        r_mem [DEPTH];

    logic          accept;
    logic          prio_ok;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_entry        mem_wd;
    logic          mem_re;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;
    assign prio_ok     = (i_req.in_priority >= PRIO_MIN) && (i_req.in_priority <= PRIO_MAX);
    assign pend_prev   = r_pend_addr - CW'(1);

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        mem_wa  = r_count[AW-1:0];
        mem_wd  = '{prio: i_req.in_priority, value: i_req.in_value};
        mem_re  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_ENQ) begin
                        mem_we = prio_ok && (r_count < DEPTH_C);
                    end else if (r_count != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                mem_re = (r_addr < r_limit);
                if (!mem_re && !r_pend) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                mem_re = (r_addr < r_count);
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = pend_prev[AW-1:0];
                    mem_wd = r_rd_data;
                end
                if (!mem_re && !r_pend) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_run   <= '0;
            r_burst <= BURST_RESET;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= mem_re;
            r_done  <= 1'b0;
            if (i_cfg_valid) begin
                r_burst <= i_cfg_burst_limit;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_req.req_type == REQ_ENQ) begin
                            r_done <= 1'b1;
                            if (mem_we) begin
                                r_count <= r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            r_done <= 1'b1;
                        end else if (r_run < r_burst) begin
                            r_run <= r_run + 4'd1;
                        end else begin
                            r_run <= '0;
                        end
                    end
                end
                ST_SHIFT: begin
                    if (n_state == ST_IDLE) begin
                        r_count <= r_count - CW'(1);
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_pend_addr <= r_addr;
        if (mem_re) begin
            r_addr <= r_addr + CW'(1);
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_result <= '{status: STAT_ENQ, out_value: '0, out_priority: '0};
                    r_addr   <= '0;
                    r_best   <= '0;
                    r_bpos   <= '0;
                    r_limit  <= (r_run < r_burst) ? r_count : CW'(1);
                    if (i_req.req_type == REQ_ENQ) begin
                        if (!prio_ok) begin
                            r_result.status <= STAT_BADPRIO;
                        end else if (r_count >= DEPTH_C) begin
                            r_result.status <= STAT_FULL;
                        end
                    end else begin
                        r_result.status <= STAT_EMPTY;
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend && (r_rd_data.prio > r_best.prio)) begin
                    r_best <= r_rd_data;
                    r_bpos <= r_pend_addr;
                end
                if (n_state == ST_SHIFT) begin
                    r_addr <= r_bpos + CW'(1);
                end
            end
            ST_SHIFT: begin
                if (n_state == ST_IDLE) begin
                    r_result <= '{status: STAT_DEQ, out_value: r_best.value,
                                  out_priority: r_best.prio};
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_enq_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.req_type == REQ_ENQ)) |=> (o_done && !busy))
        else $error("enqueue result missing");

    a_deq_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && n_state == ST_IDLE)
            |=> (o_done && o_result.status == STAT_DEQ && o_result.out_priority != '0))
        else $error("dequeue result missing or empty");

    a_scan_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_limit != '0 && r_limit <= r_count))
        else $error("scan limit out of range");

    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> !o_done)
        else $error("result during scan");
`endif

endmodule
